>>> rtl/gda_pkg.sv
package gda_pkg;

  // Operation codes carried in s_axis_tuser
  typedef enum logic [1:0] {
    FUNC_ADD  = 2'd0,
    FUNC_SUB  = 2'd1,
    FUNC_DIFF = 2'd2,
    FUNC_RSV  = 2'd3
  } func_t;

  // Datapath micro-operations
  typedef enum logic [3:0] {
    UOP_NOP,
    UOP_YBASE,
    UOP_IDXA,
    UOP_IDXB,
    UOP_OFFS,
    UOP_QEST,
    UOP_REM,
    UOP_YEAR,
    UOP_MONTH,
    UOP_DIFF,
    UOP_DONE
  } uop_t;

  // Jump conditions, evaluated after the step's operation
  typedef enum logic [1:0] {
    JC_NONE,
    JC_DIFF,
    JC_RSV,
    JC_ALWAYS
  } jcond_t;

  localparam int StepW = 4;

  // One microcode word
  typedef struct packed {
    uop_t             uop;
    logic             sel_second;
    jcond_t           jc;
    logic [StepW-1:0] target;
  } ctrl_t;

  localparam logic [11:0] YEAR_FIRST = 12'd1970;
  localparam logic [11:0] YEAR_LAST  = 12'd2099;
  // Day index of 1 January 2100
  localparam logic [15:0] RANGE_END  = 16'd47482;
  // Four-year group length and its reciprocal, exact for indexes below RANGE_END
  localparam logic [15:0] GROUP_DAYS = 16'd1461;
  localparam logic [15:0] RECIP_K    = 16'd45934;
  localparam int          RecipShift = 26;

  // Days before the first of month m
  function automatic logic [8:0] cum_days(input logic [3:0] m, input logic leap);
    logic [8:0] c;
    case (m)
      4'd2:    c = 9'd31;
      4'd3:    c = 9'd59;
      4'd4:    c = 9'd90;
      4'd5:    c = 9'd120;
      4'd6:    c = 9'd151;
      4'd7:    c = 9'd181;
      4'd8:    c = 9'd212;
      4'd9:    c = 9'd243;
      4'd10:   c = 9'd273;
      4'd11:   c = 9'd304;
      4'd12:   c = 9'd334;
      default: c = 9'd0;
    endcase
    if (leap && m > 4'd2) c = c + 9'd1;
    return c;
  endfunction

  // Length of month m, zero for a month code that means nothing
  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] n;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    n = 5'd30;
      4'd2:                                       n = leap ? 5'd29 : 5'd28;
      default:                                    n = 5'd0;
    endcase
    return n;
  endfunction

endpackage

>>> rtl/gda_seq.sv
module gda_seq (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  gda_pkg::func_t    func,
  input  logic              out_free,
  output gda_pkg::ctrl_t    ctrl,
  output logic              busy,
  output logic              finish
);

  logic [gda_pkg::StepW-1:0] step;
  gda_pkg::ctrl_t            cw;
  logic                      take_jump;

  // Microprogram: date-to-index for the first date, then add/subtract
  // and index-to-date, second date and difference, or end if reserved
  function automatic gda_pkg::ctrl_t urom(input logic [gda_pkg::StepW-1:0] s);
    gda_pkg::ctrl_t w;
    w.uop        = gda_pkg::UOP_NOP;
    w.sel_second = 1'b0;
    w.jc         = gda_pkg::JC_NONE;
    w.target     = '0;
    case (s)
      4'd0: w.uop = gda_pkg::UOP_YBASE;
      4'd1: begin
        w.uop    = gda_pkg::UOP_IDXA;
        w.jc     = gda_pkg::JC_DIFF;
        w.target = 4'd8;
      end
      4'd2: begin
        w.uop    = gda_pkg::UOP_OFFS;
        w.jc     = gda_pkg::JC_RSV;
        w.target = 4'd11;
      end
      4'd3: w.uop = gda_pkg::UOP_QEST;
      4'd4: w.uop = gda_pkg::UOP_REM;
      4'd5: w.uop = gda_pkg::UOP_YEAR;
      4'd6: begin
        w.uop    = gda_pkg::UOP_MONTH;
        w.jc     = gda_pkg::JC_ALWAYS;
        w.target = 4'd11;
      end
      4'd7: begin
        w.jc     = gda_pkg::JC_ALWAYS;
        w.target = 4'd11;
      end
      4'd8: begin
        w.uop        = gda_pkg::UOP_YBASE;
        w.sel_second = 1'b1;
      end
      4'd9: begin
        w.uop        = gda_pkg::UOP_IDXB;
        w.sel_second = 1'b1;
      end
      4'd10: w.uop = gda_pkg::UOP_DIFF;
      default: w.uop = gda_pkg::UOP_DONE;
    endcase
    return w;
  endfunction

  // Control word fetch and jump decision
  always_comb begin
    cw = urom(step);
    unique case (cw.jc)
      gda_pkg::JC_NONE:   take_jump = 1'b0;
      gda_pkg::JC_DIFF:   take_jump = (func == gda_pkg::FUNC_DIFF);
      gda_pkg::JC_RSV:    take_jump = (func == gda_pkg::FUNC_RSV);
      gda_pkg::JC_ALWAYS: take_jump = 1'b1;
      default:            take_jump = 1'b0;
    endcase
  end

  always_comb begin
    ctrl = cw;
    if (!busy) ctrl.uop = gda_pkg::UOP_NOP;
  end

  assign finish = busy && (cw.uop == gda_pkg::UOP_DONE) && out_free;

  // Step counter; the done step holds until the output register is free
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (start) begin
      busy <= 1'b1;
      step <= '0;
    end else if (busy) begin
      if (cw.uop == gda_pkg::UOP_DONE) begin
        if (out_free) busy <= 1'b0;
      end else begin
        step <= take_jump ? cw.target : step + 4'd1;
      end
    end
  end

endmodule

>>> rtl/gda_datapath.sv
module gda_datapath (
  input  logic                clk,
  input  logic                load,
  input  logic [63:0]         in_data,
  input  gda_pkg::func_t      in_func,
  input  gda_pkg::ctrl_t      ctrl,
  output gda_pkg::func_t      func,
  output logic [4:0]          day,
  output logic [3:0]          month,
  output logic [11:0]         year,
  output logic signed [16:0]  diff
);

  // Operand registers
  logic [4:0]  fd, sd;
  logic [3:0]  fm, sm;
  logic [11:0] fy, sy;
  logic [15:0] off;

  // Working registers
  logic [15:0] tbase, a, b, r;
  logic [5:0]  g;
  logic [10:0] rem;
  logic [8:0]  doy;
  logic        leap;

  // Selected date for the conversion steps
  logic [4:0]  ds;
  logic [3:0]  ms;
  logic [11:0] ys;
  logic [11:0] ydiff;
  logic [7:0]  yo;
  logic [7:0]  yo1;
  logic [15:0] ymul;
  logic        leap_in, valid_in;
  logic [15:0] idx;

  logic [16:0] sum;
  logic [31:0] prod;
  logic [15:0] gmul, rdiff;
  logic [1:0]  yig;
  logic [10:0] ystart;
  logic [3:0]  mon;
  logic [8:0]  mstart;

  assign ds = ctrl.sel_second ? sd : fd;
  assign ms = ctrl.sel_second ? sm : fm;
  assign ys = ctrl.sel_second ? sy : fy;

  // Year base: days before 1 January of the selected year
  assign ydiff = ys - gda_pkg::YEAR_FIRST;
  assign yo    = ydiff[7:0];
  assign yo1   = yo + 8'd1;
  assign ymul  = {8'd0, yo} * 16'd365;

  // Validity and day index of the selected date
  assign leap_in  = (ys[1:0] == 2'b00);
  assign valid_in = (ys >= gda_pkg::YEAR_FIRST) && (ys <= gda_pkg::YEAR_LAST) &&
                    (ds != 5'd0) && (ds <= gda_pkg::month_len(ms, leap_in));
  assign idx = valid_in ?
               tbase + {7'd0, gda_pkg::cum_days(ms, leap_in)} + {11'd0, ds} - 16'd1 :
               16'd0;

  assign sum  = {1'b0, a} + {1'b0, off};
  assign prod = r * gda_pkg::RECIP_K;
  assign gmul = {10'd0, g} * gda_pkg::GROUP_DAYS;
  assign rdiff = r - gmul;

  // Year within a four-year group; the third year is the leap year
  always_comb begin
    if (rem < 11'd365) begin
      yig = 2'd0; ystart = 11'd0;
    end else if (rem < 11'd730) begin
      yig = 2'd1; ystart = 11'd365;
    end else if (rem < 11'd1096) begin
      yig = 2'd2; ystart = 11'd730;
    end else begin
      yig = 2'd3; ystart = 11'd1096;
    end
  end

  // Month search: independent compares against the month start table
  always_comb begin
    mon = 4'd1;
    for (int i = 2; i <= 12; i++) begin
      if (doy >= gda_pkg::cum_days(4'(i), leap)) mon = 4'(i);
    end
    mstart = gda_pkg::cum_days(mon, leap);
  end

  // Operand capture on the input beat
  always_ff @(posedge clk) begin
    if (load) begin
      func <= in_func;
      fd   <= in_data[4:0];
      fm   <= in_data[8:5];
      fy   <= in_data[20:9];
      off  <= in_data[36:21];
      sd   <= in_data[41:37];
      sm   <= in_data[45:42];
      sy   <= in_data[57:46];
    end
  end

  // Micro-operation execution
  always_ff @(posedge clk) begin
    unique case (ctrl.uop)
      gda_pkg::UOP_YBASE: tbase <= ymul + {10'd0, yo1[7:2]};
      gda_pkg::UOP_IDXA:  a <= idx;
      gda_pkg::UOP_IDXB:  b <= idx;
      gda_pkg::UOP_OFFS: begin
        if (func == gda_pkg::FUNC_SUB) begin
          r <= (off > a) ? 16'd0 : a - off;
        end else begin
          r <= (sum >= {1'b0, gda_pkg::RANGE_END}) ? 16'd0 : sum[15:0];
        end
      end
      gda_pkg::UOP_QEST:  g <= prod[31:gda_pkg::RecipShift];
      gda_pkg::UOP_REM:   rem <= rdiff[10:0];
      gda_pkg::UOP_YEAR: begin
        year <= gda_pkg::YEAR_FIRST + {4'd0, g, 2'b00} + {10'd0, yig};
        leap <= (yig == 2'd2);
        doy  <= 9'(rem - ystart);
      end
      gda_pkg::UOP_MONTH: begin
        month <= mon;
        day   <= 5'(doy - mstart + 9'd1);
      end
      gda_pkg::UOP_DIFF:  diff <= $signed({1'b0, a}) - $signed({1'b0, b});
      gda_pkg::UOP_NOP, gda_pkg::UOP_DONE: ;
      default: ;
    endcase
  end

endmodule

>>> rtl/gregorian_date_arithmetic.sv
// Gregorian date arithmetic over 1 January 1970 to 31 December 2099.
// Input channel s_axis: tuser carries the operation (add, subtract,
// difference), tdata the two dates and the day offset. Output channel
// m_axis: one result beat per input beat, the result date for add and
// subtract, the signed day difference (first minus second) otherwise.
// Invalid or out-of-range dates become 1 January 1970.
// Each item runs through a microcoded sequencer, one control word per
// cycle while it is not held at its done step. Add and subtract run the
// longest microprogram, difference a shorter one and the reserved code
// the shortest.
// s_axis_tready is high while the sequencer is idle. A finished result sits
// in the output register, so the next item is taken while it waits; if the
// receiver stalls, the next item holds at its final step until the output
// register empties.
// Reset (rst, synchronous) empties the output register and idles the
// sequencer.
module gregorian_date_arithmetic (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [4:0] first_day, [8:5] first_month, [20:9] first_year,
  // [36:21] offset_days, [41:37] second_day, [45:42] second_month,
  // [57:46] second_year, [63:58] zero
  input  logic [63:0] s_axis_tdata,
  // [1:0] func
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [4:0] result_day, [8:5] result_month, [20:9] result_year,
  // [37:21] day_difference, [39:38] zero
  output logic [39:0] m_axis_tdata
);

  gda_pkg::ctrl_t     ctrl;
  gda_pkg::func_t     func;
  logic               busy, finish, start, out_free;
  logic [4:0]         day;
  logic [3:0]         month;
  logic [11:0]        year;
  logic signed [16:0] diff;

  logic [4:0]         result_day;
  logic [3:0]         result_month;
  logic [11:0]        result_year;
  logic [16:0]        day_difference;

  assign s_axis_tready = !busy;
  assign start         = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  gda_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .func     (func),
    .out_free (out_free),
    .ctrl     (ctrl),
    .busy     (busy),
    .finish   (finish)
  );

  gda_datapath u_dp (
    .clk     (clk),
    .load    (start),
    .in_data (s_axis_tdata),
    .in_func (gda_pkg::func_t'(s_axis_tuser)),
    .ctrl    (ctrl),
    .func    (func),
    .day     (day),
    .month   (month),
    .year    (year),
    .diff    (diff)
  );

  // Output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (finish) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  // Output payload, fields not used by the operation are zero
  always_ff @(posedge clk) begin
    if (finish) begin
      case (func) inside
        gda_pkg::FUNC_ADD, gda_pkg::FUNC_SUB: begin
          result_day     <= day;
          result_month   <= month;
          result_year    <= year;
          day_difference <= 17'd0;
        end
        gda_pkg::FUNC_DIFF: begin
          result_day     <= 5'd0;
          result_month   <= 4'd0;
          result_year    <= 12'd0;
          day_difference <= diff;
        end
        default: begin
          result_day     <= 5'd0;
          result_month   <= 4'd0;
          result_year    <= 12'd0;
          day_difference <= 17'd0;
        end
      endcase
    end
  end

  assign m_axis_tdata = {2'b00, day_difference, result_year, result_month, result_day};

  // Sequencer is busy right after taking a beat
  a_busy_after_start: assert property (@(posedge clk) disable iff (rst)
    start |=> !s_axis_tready)
    else $error("sequencer not busy after input beat");

  // A result beat carries either a date or a difference, never both
  a_one_kind: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[20:0] == 21'd0 || m_axis_tdata[37:21] == 17'd0))
    else $error("result beat carries date and difference");

  // A result date has month 1 to 12, a nonzero day, a year in range
  a_date_range: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[8:5] != 4'd0) |->
      (m_axis_tdata[8:5] <= 4'd12 && m_axis_tdata[4:0] != 5'd0 &&
       m_axis_tdata[20:9] >= 12'd1970 && m_axis_tdata[20:9] <= 12'd2099))
    else $error("result date out of range");

  // A result appears only at the sequencer's final step
  a_result_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(finish))
    else $error("result beat without finished item");

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

  localparam int unsigned CAL_START_YEAR = 1970;
  localparam int unsigned CAL_END_YEAR   = 2099;

  // One calendar date as it travels on the bus
  typedef struct packed {
    logic [4:0]  day;
    logic [3:0]  month;
    logic [11:0] year;
  } cal_date_t;

  typedef struct {
    gda_pkg::func_t func;
    cal_date_t      first;
    logic [15:0]    offset_days;
    cal_date_t      second;
  } date_req_t;

  typedef struct {
    logic [4:0]         day;
    logic [3:0]         month;
    logic [11:0]        year;
    logic signed [16:0] diff;
  } date_res_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;

  date_res_t pending_results[$];
  int        n_errors = 0;
  int        n_checked = 0;
  int        n_sent[4] = '{0, 0, 0, 0};
  int        burst_left = 0;
  int        stall_mode = 0;
  int        stall_left = 0;
  int        stall_phase = 0;

  gregorian_date_arithmetic i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Run limit, far above the slowest legal run
  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Calendar predictor
  // ---------------------------------------------------------------------------

  function automatic bit leap_year(int unsigned y);
    return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
  endfunction

  function automatic int unsigned days_in(int unsigned m, int unsigned y);
    case (m)
      1, 3, 5, 7, 8, 10, 12: return 31;
      4, 6, 9, 11:           return 30;
      2:                     return leap_year(y) ? 29 : 28;
      default:               return 0;
    endcase
  endfunction

  function automatic int unsigned year_days(int unsigned y);
    return leap_year(y) ? 366 : 365;
  endfunction

  // Days since 1 Jan 1970; a bad or out-of-range date counts as day zero
  function automatic int unsigned epoch_day(cal_date_t dt);
    int unsigned n;
    int unsigned i;
    n = 0;
    if (dt.year < CAL_START_YEAR || dt.year > CAL_END_YEAR || dt.month < 1 ||
        dt.month > 12 || dt.day < 1 || dt.day > days_in(dt.month, dt.year))
      return 0;
    for (i = CAL_START_YEAR; i < dt.year; i++) n += year_days(i);
    for (i = 1; i < dt.month; i++) n += days_in(i, dt.year);
    return n + dt.day - 1;
  endfunction

  function automatic date_res_t calendar_date(int unsigned n);
    int unsigned y;
    int unsigned m;
    date_res_t   res;
    y = CAL_START_YEAR;
    m = 1;
    while (n >= year_days(y)) begin
      n -= year_days(y);
      y++;
    end
    while (n >= days_in(m, y)) begin
      n -= days_in(m, y);
      m++;
    end
    res.day   = 5'(n + 1);
    res.month = 4'(m);
    res.year  = 12'(y);
    res.diff  = '0;
    return res;
  endfunction

  function automatic cal_date_t on_date(int unsigned d, int unsigned m, int unsigned y);
    cal_date_t dt;
    dt.day   = 5'(d);
    dt.month = 4'(m);
    dt.year  = 12'(y);
    return dt;
  endfunction

  function automatic date_res_t predict_date_result(date_req_t q);
    int unsigned a;
    int unsigned b;
    int unsigned r;
    int unsigned span;
    date_res_t   res;
    res  = '{default: '0};
    a    = epoch_day(q.first);
    span = epoch_day(on_date(31, 12, CAL_END_YEAR)) + 1;
    case (q.func)
      gda_pkg::FUNC_ADD: begin
        r = a + q.offset_days;
        if (r >= span) r = 0;
        res = calendar_date(r);
      end
      gda_pkg::FUNC_SUB: begin
        r = (q.offset_days > a) ? 0 : a - q.offset_days;
        res = calendar_date(r);
      end
      gda_pkg::FUNC_DIFF: begin
        b = epoch_day(q.second);
        res.diff = 17'(int'(a) - int'(b));
      end
      default: ;
    endcase
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic date_req_t make_req(gda_pkg::func_t f, cal_date_t a, int unsigned off,
                                         cal_date_t b);
    date_req_t q;
    q.func        = f;
    q.first       = a;
    q.offset_days = 16'(off);
    q.second      = b;
    return q;
  endfunction

  // Valid date, biased toward the two ends of the calendar
  function automatic cal_date_t random_date();
    int unsigned y;
    int unsigned m;
    case ($urandom_range(0, 9))
      0:       y = $urandom_range(CAL_START_YEAR, CAL_START_YEAR + 2);
      1:       y = $urandom_range(CAL_END_YEAR - 2, CAL_END_YEAR);
      default: y = $urandom_range(CAL_START_YEAR, CAL_END_YEAR);
    endcase
    m = $urandom_range(1, 12);
    return on_date($urandom_range(1, days_in(m, y)), m, y);
  endfunction

  function automatic int unsigned random_offset();
    case ($urandom_range(0, 3))
      0:       return $urandom_range(0, 40);
      1:       return $urandom_range(0, 2000);
      2:       return $urandom_range(0, 47481);
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  // Any bit pattern, or a near miss of a valid date
  function automatic cal_date_t noise_date();
    cal_date_t dt;
    dt = random_date();
    case ($urandom_range(0, 4))
      0: dt = cal_date_t'(21'($urandom));
      1: dt.day = 5'($urandom_range(29, 31));
      2: dt.year = ($urandom_range(0, 1) == 0) ? 12'd1969 : 12'd2100;
      3: dt.month = 4'($urandom_range(13, 15));
      default: dt.year = 12'($urandom);
    endcase
    return dt;
  endfunction

  // Sends one beat; bursts of random length separated by random gaps
  task automatic send_item(input date_req_t q);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, ($urandom_range(0, 4) == 0) ? 60 : 8);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= q.func;
    s_axis_tdata  <= {6'b0, q.second.year, q.second.month, q.second.day, q.offset_days,
                      q.first.year, q.first.month, q.first.day};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    pending_results.push_back(predict_date_result(q));
    n_sent[q.func]++;
    burst_left--;
  endtask

  // ---------------------------------------------------------------------------
  // Result checking and receiver stalls
  // ---------------------------------------------------------------------------

  task automatic check_result(input logic [39:0] beat);
    date_res_t want;
    date_res_t got;
    got.day   = beat[4:0];
    got.month = beat[8:5];
    got.year  = beat[20:9];
    got.diff  = beat[37:21];
    if (pending_results.size() == 0) begin
      $error("result beat with nothing expected: %h", beat);
      n_errors++;
      return;
    end
    want = pending_results.pop_front();
    n_checked++;
    if (got.day !== want.day) begin
      $error("result_day: expected %0d, got %0d", want.day, got.day);
      n_errors++;
    end
    if (got.month !== want.month) begin
      $error("result_month: expected %0d, got %0d", want.month, got.month);
      n_errors++;
    end
    if (got.year !== want.year) begin
      $error("result_year: expected %0d, got %0d", want.year, got.year);
      n_errors++;
    end
    if (got.diff !== want.diff) begin
      $error("day_difference: expected %0d, got %0d", want.diff, got.diff);
      n_errors++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) check_result(m_axis_tdata);
    // stall pattern: free running, coin flip, rare ready, mostly ready
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(16, 96);
    end
    stall_left--;
    stall_phase++;
    case (stall_mode)
      0:       m_axis_tready <= 1'b1;
      1:       m_axis_tready <= $urandom_range(0, 1);
      2:       m_axis_tready <= (stall_phase % 7 == 0);
      default: m_axis_tready <= ($urandom_range(0, 9) != 0);
    endcase
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Ends of the calendar and of the offset field
  task automatic test_range_limits();
    cal_date_t d0;
    cal_date_t d1;
    d0 = on_date(1, 1, CAL_START_YEAR);
    d1 = on_date(31, 12, CAL_END_YEAR);
    send_item(make_req(gda_pkg::FUNC_ADD, d0, 0, d0));
    send_item(make_req(gda_pkg::FUNC_ADD, d0, 47481, d0));
    send_item(make_req(gda_pkg::FUNC_ADD, d1, 0, d0));
    send_item(make_req(gda_pkg::FUNC_ADD, d1, 1, d0));       // past the end
    send_item(make_req(gda_pkg::FUNC_ADD, d0, 65535, cal_date_t'('1)));
    send_item(make_req(gda_pkg::FUNC_SUB, d0, 1, d0));       // before the start
    send_item(make_req(gda_pkg::FUNC_SUB, d1, 47481, d0));
    send_item(make_req(gda_pkg::FUNC_SUB, d1, 65535, d0));
    send_item(make_req(gda_pkg::FUNC_SUB, d1, 0, cal_date_t'('1)));
  endtask

  // 400-year rule in 2000, plain leap and non-leap years
  task automatic test_leap_years();
    send_item(make_req(gda_pkg::FUNC_SUB, on_date(1, 3, 2000), 1, on_date(0, 0, 0)));
    send_item(make_req(gda_pkg::FUNC_ADD, on_date(28, 2, 2096), 1, on_date(0, 0, 0)));
    send_item(make_req(gda_pkg::FUNC_ADD, on_date(28, 2, 2001), 1, on_date(0, 0, 0)));
    send_item(make_req(gda_pkg::FUNC_ADD, on_date(29, 2, 2001), 0, on_date(0, 0, 0)));
  endtask

  // Each kind of bad date falls back to 1 Jan 1970
  task automatic test_invalid_dates();
    send_item(make_req(gda_pkg::FUNC_ADD, on_date(0, 5, 2010), 10, on_date(0, 0, 0)));
    send_item(make_req(gda_pkg::FUNC_ADD, on_date(15, 0, 2010), 10, on_date(0, 0, 0)));
    send_item(make_req(gda_pkg::FUNC_ADD, on_date(15, 15, 2010), 10, on_date(0, 0, 0)));
    send_item(make_req(gda_pkg::FUNC_ADD, on_date(31, 4, 2010), 10, on_date(0, 0, 0)));
    send_item(make_req(gda_pkg::FUNC_SUB, on_date(31, 12, 1969), 0, on_date(0, 0, 0)));
    send_item(make_req(gda_pkg::FUNC_SUB, on_date(1, 1, 2100), 0, on_date(0, 0, 0)));
    send_item(make_req(gda_pkg::FUNC_ADD, on_date(31, 15, 4095), 5, on_date(0, 0, 0)));
  endtask

  // Signed difference both ways, equal dates, bad second date
  task automatic test_difference();
    cal_date_t d0;
    cal_date_t d1;
    d0 = on_date(1, 1, CAL_START_YEAR);
    d1 = on_date(31, 12, CAL_END_YEAR);
    send_item(make_req(gda_pkg::FUNC_DIFF, d1, 65535, d0));
    send_item(make_req(gda_pkg::FUNC_DIFF, d0, 0, d1));
    send_item(make_req(gda_pkg::FUNC_DIFF, on_date(29, 2, 2000), 0, on_date(29, 2, 2000)));
    send_item(make_req(gda_pkg::FUNC_DIFF, on_date(4, 7, 2024), 0, on_date(31, 13, 4095)));
  endtask

  task automatic test_reserved_code();
    send_item(make_req(gda_pkg::FUNC_RSV, cal_date_t'('1), 65535, cal_date_t'('1)));
  endtask

  // Well-formed dates with random offsets, all three operations
  task automatic test_random_dates(input int count);
    gda_pkg::func_t f;
    repeat (count) begin
      f = gda_pkg::func_t'($urandom_range(0, 2));
      send_item(make_req(f, random_date(), random_offset(), random_date()));
    end
  endtask

  // Raw and near-miss field values, reserved code included
  task automatic test_random_noise(input int count);
    repeat (count) begin
      send_item(make_req(gda_pkg::func_t'($urandom_range(0, 3)), noise_date(),
                         $urandom_range(0, 65535), noise_date()));
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    test_range_limits();
    test_leap_years();
    test_invalid_dates();
    test_difference();
    test_reserved_code();
    test_random_dates(900);
    test_random_noise(300);

    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Sent %0d add, %0d subtract, %0d difference and %0d reserved beats;",
             n_sent[gda_pkg::FUNC_ADD], n_sent[gda_pkg::FUNC_SUB],
             n_sent[gda_pkg::FUNC_DIFF], n_sent[gda_pkg::FUNC_RSV]);
    $display("checked %0d result beats, %0d mismatches.", n_checked, n_errors);
    if (n_errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/gda_pkg.sv
rtl/gda_seq.sv
rtl/gda_datapath.sv
rtl/gregorian_date_arithmetic.sv
dv/tb_top.sv
